### rtl/csu_pkg.sv
// Shared types, character constants and helper functions for the C string unescape core.
// Used by csu_decode, csu_out_buf and the top level c_string_unescape_core.
package csu_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX1 = 2'd2,
        MODE_HEX2 = 2'd3
    } mode_t;

    localparam int unsigned MAX_RESULTS = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_BS     = 8'h08;

    // Results produced by one source byte, in output order from entry zero.
    typedef struct packed {
        logic [2:0]                   cnt;
        logic                         term;
        logic [MAX_RESULTS-1:0][7:0]  data;
    } bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d = c - 8'h30;
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

### rtl/c_string_unescape_core.sv
// C string unescape core: decodes a C-escaped byte stream into raw bytes.
// Depends on csu_pkg, csu_decode and csu_out_buf.
//
// Source bytes enter on the s_ channel, one per transaction; a zero byte ends a string and
// causes a terminating NUL with m_tlast high. A source byte first lands in an input register,
// is decoded from there into between zero and four result bytes once the result register is
// free, and those are held in that result register, which sends one byte per cycle while the
// receiver is ready. The rate is one source byte per cycle as long as each byte yields at most
// one result and the receiver does not stall; a byte that yields several results holds the
// result register until its last one is taken, and the input register absorbs one further byte.
module c_string_unescape_core
    import csu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       s_accept;
    logic       buf_load;
    logic       buf_free;
    bundle_t    bundle;

    assign buf_load = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_load;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (buf_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_accept) begin
            in_data_reg <= s_tdata;
        end
    end

    csu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (buf_load),
        .ch      (in_data_reg),
        .bundle  (bundle)
    );

    csu_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bundle   (bundle),
        .load     (buf_load),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/csu_decode.sv
// Escape decoder: holds the escape state and turns one source byte into a bundle of results.
// Depends on csu_pkg.
module csu_decode
    import csu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic [7:0] ch,
    output bundle_t    bundle
);

    mode_t      mode_reg, mode_next;
    logic [7:0] fhc_reg, fhc_next;

    logic       p_cnt;
    logic [7:0] p_byte;
    logic       p_term;
    mode_t      p_mode;
    logic [7:0] p_fhc;
    logic [7:0] hex_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            fhc_reg  <= 8'h00;
        end else if (adv) begin
            mode_reg <= mode_next;
            fhc_reg  <= fhc_next;
        end
    end

    // Plain-text handling, also used after a malformed hex escape.
    always_comb begin
        p_byte = ch;
        p_term = 1'b0;
        p_cnt  = 1'b1;
        p_mode = MODE_TEXT;
        p_fhc  = fhc_reg;
        if (ch == CH_NUL) begin
            p_term = 1'b1;
            p_fhc  = 8'h00;
        end else if (ch == CH_BSLASH) begin
            p_cnt  = 1'b0;
            p_mode = MODE_ESC;
        end
    end

    assign hex_byte = {hex_val(fhc_reg), hex_val(ch)};

    always_comb begin
        bundle.cnt  = 3'd0;
        bundle.term = 1'b0;
        bundle.data = '0;
        mode_next   = MODE_TEXT;
        fhc_next    = fhc_reg;
        unique case (mode_reg)
            MODE_TEXT: begin
                bundle.data[0] = p_byte;
                bundle.cnt     = {2'b00, p_cnt};
                bundle.term    = p_term;
                mode_next      = p_mode;
                fhc_next       = p_fhc;
            end
            MODE_ESC: begin
                priority if (ch == CH_NUL) begin
                    bundle.data[0] = CH_BSLASH;
                    bundle.data[1] = CH_NUL;
                    bundle.cnt     = 3'd2;
                    bundle.term    = 1'b1;
                    fhc_next       = 8'h00;
                end else if (ch == CH_BSLASH) begin
                    bundle.data[0] = CH_BSLASH;
                    bundle.cnt     = 3'd1;
                end else if (ch == CH_N) begin
                    bundle.data[0] = CH_LF;
                    bundle.cnt     = 3'd1;
                end else if (ch == CH_R) begin
                    bundle.data[0] = CH_CR;
                    bundle.cnt     = 3'd1;
                end else if (ch == CH_V) begin
                    bundle.data[0] = CH_VT;
                    bundle.cnt     = 3'd1;
                end else if (ch == CH_B) begin
                    bundle.data[0] = CH_BS;
                    bundle.cnt     = 3'd1;
                end else if (ch == CH_ZERO) begin
                    bundle.data[0] = CH_BSLASH;
                    bundle.data[1] = CH_NUL;
                    bundle.cnt     = 3'd2;
                end else if (ch == CH_X) begin
                    mode_next = MODE_HEX1;
                end else begin
                    bundle.data[0] = CH_BSLASH;
                    bundle.data[1] = ch;
                    bundle.cnt     = 3'd2;
                end
            end
            MODE_HEX1: begin
                if (is_hex(ch)) begin
                    fhc_next  = ch;
                    mode_next = MODE_HEX2;
                end else begin
                    bundle.data[0] = CH_BSLASH;
                    bundle.data[1] = CH_X;
                    bundle.data[2] = p_byte;
                    bundle.cnt     = 3'd2 + {2'b00, p_cnt};
                    bundle.term    = p_term;
                    mode_next      = p_mode;
                    fhc_next       = p_fhc;
                end
            end
            MODE_HEX2: begin
                fhc_next = 8'h00;
                if (is_hex(ch)) begin
                    if (hex_byte == CH_NUL) begin
                        bundle.data[0] = CH_BSLASH;
                        bundle.data[1] = CH_NUL;
                        bundle.cnt     = 3'd2;
                    end else begin
                        bundle.data[0] = hex_byte;
                        bundle.cnt     = 3'd1;
                    end
                end else begin
                    bundle.data[0] = CH_BSLASH;
                    bundle.data[1] = CH_X;
                    bundle.data[2] = fhc_reg;
                    bundle.data[3] = p_byte;
                    bundle.cnt     = 3'd3 + {2'b00, p_cnt};
                    bundle.term    = p_term;
                    mode_next      = p_mode;
                end
            end
            default: begin
                mode_next = MODE_TEXT;
            end
        endcase
    end

endmodule

### rtl/csu_out_buf.sv
// Result register: holds one decoded bundle and sends its bytes out one per cycle while m_tready is high.
// Depends on csu_pkg.
module csu_out_buf
    import csu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  bundle_t    bundle,
    input  logic       load,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    bundle_t    bundle_reg, bundle_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [1:0] cnt_m1;
    logic       at_end;
    logic       take;

    assign cnt_m1   = 2'(bundle_reg.cnt - 3'd1);
    assign at_end   = (idx_reg == cnt_m1);
    assign take     = valid_reg && m_tready;
    assign free     = !valid_reg || (take && at_end);
    assign m_tvalid = valid_reg;
    assign m_tdata  = bundle_reg.data[idx_reg];
    assign m_tlast  = bundle_reg.term && at_end;

    always_comb begin
        bundle_next = bundle_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        if (take) begin
            if (at_end) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load && (bundle.cnt != 3'd0)) begin
            bundle_next = bundle;
            idx_next    = 2'd0;
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        bundle_reg <= bundle_next;
    end

endmodule

### rtl/csu_checker.sv
// Port-level checks for c_string_unescape_core, attached to the top level by a bind.
// Depends only on the top level's ports.
module csu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The end-of-string marker is only ever carried by a NUL byte.
    a_last_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'h00)
        else $error("last asserted on a non-NUL byte");

    // With no result pending, the input side is never blocked.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind c_string_unescape_core csu_checker u_csu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/tb_c_string_unescape_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for c_string_unescape_core: drives escaped strings with bursty input
// and a stalling receiver, and checks every decoded byte against a scoreboard predictor.
// Depends on csu_pkg and the c_string_unescape_core RTL.
module tb_c_string_unescape_core;
    import csu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       term;
    } decoded_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_HALF,
        RX_SPARSE
    } rx_pattern_t;

    // Predicts the decoded bytes and compares each output transaction with the oldest one.
    class decoded_byte_board;
        mode_t      esc_state;
        logic [7:0] held_digit;
        decoded_t   expected_q[$];
        int         errors;

        function new();
            esc_state  = MODE_TEXT;
            held_digit = 8'h00;
            errors     = 0;
        endfunction

        static function int digit_value(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
            return -1;
        endfunction

        function void expect_byte(logic [7:0] v, logic t);
            decoded_t d;
            d.value = v;
            d.term  = t;
            expected_q.push_back(d);
        endfunction

        function void plain_byte(logic [7:0] c);
            if (c == CH_NUL) begin
                expect_byte(CH_NUL, 1'b1);
                esc_state  = MODE_TEXT;
                held_digit = 8'h00;
            end else if (c == CH_BSLASH) begin
                esc_state = MODE_ESC;
            end else begin
                expect_byte(c, 1'b0);
                esc_state = MODE_TEXT;
            end
        endfunction

        function void take_source_byte(logic [7:0] c);
            int         hi;
            int         lo;
            logic [7:0] val;
            case (esc_state)
                MODE_TEXT: begin
                    plain_byte(c);
                end
                MODE_ESC: begin
                    esc_state = MODE_TEXT;
                    if (c == CH_NUL) begin
                        expect_byte(CH_BSLASH, 1'b0);
                        plain_byte(c);
                    end else if (c == CH_BSLASH) begin
                        expect_byte(CH_BSLASH, 1'b0);
                    end else if (c == CH_N) begin
                        expect_byte(CH_LF, 1'b0);
                    end else if (c == CH_R) begin
                        expect_byte(CH_CR, 1'b0);
                    end else if (c == CH_V) begin
                        expect_byte(CH_VT, 1'b0);
                    end else if (c == CH_B) begin
                        expect_byte(CH_BS, 1'b0);
                    end else if (c == CH_ZERO) begin
                        expect_byte(CH_BSLASH, 1'b0);
                        expect_byte(CH_NUL, 1'b0);
                    end else if (c == CH_X) begin
                        esc_state = MODE_HEX1;
                    end else begin
                        expect_byte(CH_BSLASH, 1'b0);
                        expect_byte(c, 1'b0);
                    end
                end
                MODE_HEX1: begin
                    if (digit_value(c) >= 0) begin
                        held_digit = c;
                        esc_state  = MODE_HEX2;
                    end else begin
                        expect_byte(CH_BSLASH, 1'b0);
                        expect_byte(CH_X, 1'b0);
                        esc_state = MODE_TEXT;
                        plain_byte(c);
                    end
                end
                default: begin
                    lo = digit_value(c);
                    if (lo >= 0) begin
                        hi  = digit_value(held_digit);
                        val = 8'((hi << 4) | lo);
                        if (val == CH_NUL) begin
                            expect_byte(CH_BSLASH, 1'b0);
                            expect_byte(CH_NUL, 1'b0);
                        end else begin
                            expect_byte(val, 1'b0);
                        end
                        esc_state  = MODE_TEXT;
                        held_digit = 8'h00;
                    end else begin
                        expect_byte(CH_BSLASH, 1'b0);
                        expect_byte(CH_X, 1'b0);
                        expect_byte(held_digit, 1'b0);
                        esc_state  = MODE_TEXT;
                        held_digit = 8'h00;
                        plain_byte(c);
                    end
                end
            endcase
        endfunction

        function void flag(string what, decoded_t want, logic [7:0] v, logic t);
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("%s: expected %02h last %0b, got %02h last %0b",
                         what, want.value, want.term, v, t);
            end
        endfunction

        function void check_decoded(logic [7:0] v, logic t);
            decoded_t want;
            if (expected_q.size() == 0) begin
                want = '0;
                flag("Unexpected output byte", want, v, t);
            end else begin
                want = expected_q.pop_front();
                if (want.value !== v || want.term !== t) begin
                    flag("Output byte mismatch", want, v, t);
                end
            end
        endfunction

        function void flag_leftovers();
            decoded_t want;
            while (expected_q.size() != 0) begin
                want = expected_q.pop_front();
                flag("Missing output byte", want, 8'h00, 1'b0);
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    decoded_byte_board board = new();
    logic [7:0]        source_bytes[$];
    int                cycle_count = 0;
    rx_pattern_t       rx_pattern = RX_OPEN;
    int                rx_left = 0;
    logic [1:0]        rx_phase = 2'd0;

    c_string_unescape_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            board.take_source_byte(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            board.check_decoded(m_tdata, m_tlast);
        end
    end

    // The receiver switches between stall patterns, including stretches with no stalls.
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 2'd1;
        if (rx_left == 0) begin
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
            rx_left    <= $urandom_range(16, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_pattern)
            RX_OPEN:   m_tready <= 1'b1;
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
            default:   m_tready <= (rx_phase == 2'd0);
        endcase
    end

    function automatic logic [7:0] random_hex_digit();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return CH_ZERO + 8'(k);
        if (k < 16) return 8'h61 + 8'(k - 10);
        return 8'h41 + 8'(k - 16);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) return CH_NUL;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (decoded_byte_board::digit_value(c) >= 0);
        return c;
    endfunction

    task automatic build_stimulus();
        int         pick;
        int         directed;
        logic [7:0] c;
        // Every escape, hex in mixed case, the NUL-producing escapes, an unknown escape
        // with an all-ones byte, and strings that end inside an escape.
        source_bytes = {CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_N, CH_BSLASH, CH_R,
                        CH_BSLASH, CH_V, CH_BSLASH, CH_B, CH_BSLASH, CH_ZERO,
                        CH_BSLASH, CH_X, CH_ZERO, CH_ZERO,
                        CH_BSLASH, CH_X, 8'h61, 8'h46,
                        CH_BSLASH, 8'hFF,
                        CH_BSLASH, CH_X, 8'h37, CH_NUL,
                        CH_BSLASH, CH_NUL,
                        CH_BSLASH, CH_X, CH_NUL};
        directed = source_bytes.size();
        while (source_bytes.size() < directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                do begin
                    c = 8'($urandom_range(1, 255));
                end while (c == CH_BSLASH);
                source_bytes.push_back(c);
            end else if (pick < 45) begin
                source_bytes.push_back(CH_BSLASH);
                case ($urandom_range(0, 5))
                    0:       c = CH_BSLASH;
                    1:       c = CH_N;
                    2:       c = CH_R;
                    3:       c = CH_V;
                    4:       c = CH_B;
                    default: c = CH_ZERO;
                endcase
                source_bytes.push_back(c);
            end else if (pick < 63) begin
                source_bytes.push_back(CH_BSLASH);
                source_bytes.push_back(CH_X);
                if ($urandom_range(0, 7) == 0) begin
                    source_bytes.push_back(CH_ZERO);
                    source_bytes.push_back(CH_ZERO);
                end else begin
                    source_bytes.push_back(random_hex_digit());
                    source_bytes.push_back(random_hex_digit());
                end
            end else if (pick < 73) begin
                source_bytes.push_back(CH_NUL);
            end else if (pick < 80) begin
                source_bytes.push_back(CH_BSLASH);
                source_bytes.push_back(8'($urandom_range(1, 255)));
            end else if (pick < 88) begin
                source_bytes.push_back(CH_BSLASH);
                source_bytes.push_back(CH_X);
                if ($urandom_range(0, 1) == 1) begin
                    source_bytes.push_back(random_hex_digit());
                end
                source_bytes.push_back(random_non_hex());
            end else if (pick < 92) begin
                source_bytes.push_back(CH_BSLASH);
                source_bytes.push_back(CH_NUL);
            end else begin
                source_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        source_bytes.push_back(CH_NUL);
    endtask

    // Each source byte is one transaction; bursts of random length with random gaps between.
    task automatic send_source();
        int k;
        int burst;
        int gap;
        k = 0;
        while (k < source_bytes.size()) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && k < source_bytes.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= source_bytes[k];
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                k++;
                burst--;
            end
            gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_source();
        @(posedge aclk);
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.flag_leftovers();
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
